// ===== design/cbs_pkg.sv =====
// Shared types, widths and command codes of the cubic B-spline interpolator.
package cbs_pkg;

  localparam int unsigned MaxPointsDef = 256;
  localparam int unsigned FracBitsDef  = 16;

  localparam int unsigned ShapeW = 32;
  localparam int unsigned PosW   = 25;
  localparam int unsigned CpW    = 48;
  localparam int unsigned RatW   = 21;
  localparam int unsigned ProdW  = CpW + RatW;
  localparam int unsigned Sum1W  = ProdW + 2;
  localparam int unsigned Sum2W  = 21;
  localparam int unsigned WgtW   = 20;
  localparam int unsigned DivW   = 64;
  localparam int unsigned DenW   = 28;

  typedef struct packed {
    logic                     req_type;
    logic signed [ShapeW-1:0] shape_value;
    logic                     last_point;
    logic [PosW-1:0]          position;
  } cbs_req_t;

  typedef struct packed {
    logic signed [31:0] curve_value;
    logic [1:0]         status;
  } cbs_res_t;

  localparam logic [1:0] StOk        = 2'd0;
  localparam logic [1:0] StNoSupport = 2'd1;
  localparam logic [1:0] StNoCurve   = 2'd2;

  typedef logic [4:0] cbs_op_t;

  localparam cbs_op_t OpNone   = 5'd0;
  localparam cbs_op_t OpAccept = 5'd1;
  localparam cbs_op_t OpSinit  = 5'd2;
  localparam cbs_op_t OpFrd    = 5'd3;
  localparam cbs_op_t OpFq     = 5'd4;
  localparam cbs_op_t OpFz     = 5'd5;
  localparam cbs_op_t OpLstart = 5'd6;
  localparam cbs_op_t OpLwr    = 5'd7;
  localparam cbs_op_t OpBrd    = 5'd8;
  localparam cbs_op_t OpBmul   = 5'd9;
  localparam cbs_op_t OpBwr    = 5'd10;
  localparam cbs_op_t OpSdone  = 5'd11;
  localparam cbs_op_t OpEt2    = 5'd12;
  localparam cbs_op_t OpEt3    = 5'd13;
  localparam cbs_op_t OpEs2    = 5'd14;
  localparam cbs_op_t OpEs3    = 5'd15;
  localparam cbs_op_t OpEw     = 5'd16;
  localparam cbs_op_t OpErd    = 5'd17;
  localparam cbs_op_t OpEmul   = 5'd18;
  localparam cbs_op_t OpEacc   = 5'd19;
  localparam cbs_op_t OpEdiv   = 5'd20;
  localparam cbs_op_t OpEout   = 5'd21;
  localparam cbs_op_t OpEnr    = 5'd22;

  typedef struct packed {
    logic is_eval;
    logic last_point;
    logic ready;
    logic div_done;
    logic fwd_end;
    logic bk_end;
    logic k_last;
    logic sum_zero;
  } cbs_stat_t;

endpackage

// ===== design/cbs_div.sv =====
// Radix-2 restoring divider, one quotient bit per cycle.
module cbs_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [cbs_pkg::DivW-1:0]  num_i,
  input  logic [cbs_pkg::DenW-1:0]  den_i,
  output logic                      done_o,
  output logic [cbs_pkg::DivW-1:0]  quot_o
);
  import cbs_pkg::*;

  localparam int unsigned CntW = $clog2(DivW + 1);

  logic [DivW-1:0] num_q;
  logic [DenW-1:0] rem_q, den_q;
  logic [CntW-1:0] cnt_q;
  logic            run_q, done_q;
  logic [DenW:0]   sh_w, diff_w;

  assign sh_w   = {rem_q, num_q[DivW-1]};
  assign diff_w = sh_w - {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= CntW'(DivW);
      end else if (run_q) begin
        cnt_q <= cnt_q - CntW'(1);
        if (cnt_q == CntW'(1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= num_i;
      den_q <= den_i;
      rem_q <= '0;
    end else if (run_q) begin
      // A clear borrow bit means the shifted remainder covers the divisor.
      rem_q <= diff_w[DenW] ? sh_w[DenW-1:0] : diff_w[DenW-1:0];
      num_q <= {num_q[DivW-2:0], ~diff_w[DenW]};
    end
  end

  assign done_o = done_q;
  assign quot_o = num_q;

endmodule

// ===== design/cbs_dp.sv =====
// Datapath: stores, multiplier and registers for the solve and the evaluation.
module cbs_dp #(
  parameter int unsigned MAX_POINTS = cbs_pkg::MaxPointsDef,
  parameter int unsigned FRAC_BITS  = cbs_pkg::FracBitsDef
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  cbs_pkg::cbs_op_t          op_i,
  input  cbs_pkg::cbs_req_t         req_i,
  input  logic                      div_done_i,
  input  logic [cbs_pkg::DivW-1:0]  quot_i,
  output logic                      div_start_o,
  output logic [cbs_pkg::DivW-1:0]  num_o,
  output logic [cbs_pkg::DenW-1:0]  den_o,
  output cbs_pkg::cbs_stat_t        stat_o,
  output cbs_pkg::cbs_res_t         res_o,
  output logic                      valid_o
);
  import cbs_pkg::*;

  localparam int unsigned SAW     = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int unsigned PCW     = $clog2(MAX_POINTS + 1);
  localparam int unsigned CpDepth = MAX_POINTS + 2;
  localparam int unsigned CW      = $clog2(CpDepth);
  localparam int unsigned SEGW    = PosW - FRAC_BITS;
  localparam int unsigned IXW     = ((SEGW > CW) ? SEGW : CW) + 2;

  logic signed [ShapeW-1:0] shape_mem [MAX_POINTS];
  logic signed [CpW-1:0]    cp_mem    [CpDepth];
  logic signed [RatW-1:0]   piv_mem   [CpDepth];

  cbs_req_t                 req_q;
  cbs_res_t                 res_q;
  logic                     valid_q, ready_q;
  logic [PCW-1:0]           pc_q;
  logic [CW-1:0]            last_q, i_q;
  logic [1:0]               k_q;
  logic signed [RatW-1:0]   qprev_q, qcur_q, piv_rd_q;
  logic signed [CpW-1:0]    zprev_q, xnext_q, cp_rd_q;
  logic signed [ShapeW-1:0] shape_rd_q;
  logic signed [ProdW-1:0]  prod_q;
  logic [16:0]              t2_q, t3_q;
  logic signed [WgtW-1:0]   w_q [4];
  logic signed [Sum1W-1:0]  sum1_q;
  logic signed [Sum2W-1:0]  sum2_q;

  function automatic logic signed [51:0] rnd20(input logic signed [ProdW-1:0] v);
    logic [ProdW-1:0] mag;
    logic [ProdW-1:0] r;
    mag = v[ProdW-1] ? ProdW'(-v) : ProdW'(v);
    r   = (mag + ProdW'(524288)) >> 20;
    return v[ProdW-1] ? -$signed(r[51:0]) : $signed(r[51:0]);
  endfunction

  function automatic logic signed [CpW-1:0] clamp42(input logic signed [51:0] v);
    if (v > 52'sd4398046511104) return 48'sd4398046511104;
    if (v < -52'sd4398046511104) return -48'sd4398046511104;
    return v[CpW-1:0];
  endfunction

  // Position split into segment and a 16-bit fraction.
  logic [15:0]     t_w;
  logic [16:0]     s_w;
  logic [SEGW-1:0] seg_w;
  logic [IXW-1:0]  idx_w;
  logic            incl_w;

  if (FRAC_BITS >= 16) begin : g_t_hi
    assign t_w = req_q.position[FRAC_BITS-1 -: 16];
  end else begin : g_t_lo
    assign t_w = {req_q.position[FRAC_BITS-1:0], {(16-FRAC_BITS){1'b0}}};
  end

  assign s_w    = 17'd65536 - {1'b0, t_w};
  assign seg_w  = req_q.position[PosW-1:FRAC_BITS];
  assign idx_w  = IXW'(seg_w) + IXW'(k_q) - IXW'(3);
  assign incl_w = !idx_w[IXW-1] && (idx_w <= IXW'(last_q));

  // Forward-pass right side minus the previous z.
  logic signed [CpW-1:0] sx_w, diff_w;
  assign sx_w   = CpW'(shape_rd_q);
  assign diff_w = (sx_w <<< 10) + (sx_w <<< 9) - zprev_q;

  logic [16:0] prod_hi_w;
  assign prod_hi_w = prod_q[32:16];

  logic signed [CpW-1:0]   a_w;
  logic signed [RatW-1:0]  b_w;
  logic signed [ProdW-1:0] prod_w;

  always_comb begin
    a_w = '0;
    b_w = '0;
    unique case (op_i)
      OpFq: begin
        a_w = diff_w;
        b_w = $signed(quot_i[RatW-1:0]);
      end
      OpBmul: begin
        a_w = xnext_q;
        b_w = piv_rd_q;
      end
      OpEt2: begin
        a_w = $signed(CpW'(t_w));
        b_w = $signed(RatW'(t_w));
      end
      OpEt3: begin
        a_w = $signed(CpW'(prod_hi_w));
        b_w = $signed(RatW'(t_w));
      end
      OpEs2: begin
        a_w = $signed(CpW'(s_w));
        b_w = $signed(RatW'(s_w));
      end
      OpEs3: begin
        a_w = $signed(CpW'(prod_hi_w));
        b_w = $signed(RatW'(s_w));
      end
      OpEmul: begin
        a_w = cp_rd_q;
        b_w = RatW'(w_q[k_q]);
      end
      default: begin
        a_w = '0;
        b_w = '0;
      end
    endcase
  end

  assign prod_w = a_w * b_w;

  logic signed [51:0]    rnd_w;
  logic signed [CpW-1:0] z_fwd_w, x_bk_w, x_last_w;
  logic [CpW-1:0]        zmag_w, qc_w;

  assign rnd_w    = rnd20(prod_q);
  assign z_fwd_w  = clamp42(rnd_w);
  assign x_bk_w   = clamp42(52'(cp_rd_q) - rnd_w);
  assign zmag_w   = zprev_q[CpW-1] ? CpW'(-zprev_q) : CpW'(zprev_q);
  assign qc_w     = (quot_i > 64'd4398046511104) ? 48'd4398046511104 : quot_i[CpW-1:0];
  assign x_last_w = zprev_q[CpW-1] ? -$signed(qc_w) : $signed(qc_w);

  // Basis weights of the segment, one = 2^16.
  logic signed [21:0] t2e_w, t3e_w, te_w, w1_w, w2_w;
  assign t2e_w = $signed(22'(t2_q));
  assign t3e_w = $signed(22'(t3_q));
  assign te_w  = $signed(22'(t_w));
  assign w1_w  = 22'sd3 * t3e_w - 22'sd6 * t2e_w + 22'sd262144;
  assign w2_w  = -(22'sd3 * t3e_w) + 22'sd3 * t2e_w + 22'sd3 * te_w + 22'sd65536;

  // Divider operands.
  logic signed [23:0]   p_w;
  logic signed [21:0]   dl_w;
  logic [DenW-1:0]      de_w;
  logic [Sum1W-1:0]     smag_w;

  assign p_w    = 24'sd4194304 - 24'(qprev_q);
  assign dl_w   = 22'sd1048576 + 22'(qprev_q);
  assign de_w   = {sum2_q[19:0], 8'b0};
  assign smag_w = sum1_q[Sum1W-1] ? Sum1W'(-sum1_q) : Sum1W'(sum1_q);

  always_comb begin
    div_start_o = 1'b0;
    num_o       = '0;
    den_o       = '0;
    unique case (op_i)
      OpFrd: begin
        div_start_o = 1'b1;
        den_o       = DenW'(p_w);
        num_o       = 64'd1099511627776 + 64'(p_w[23:1]);
      end
      OpLstart: begin
        div_start_o = 1'b1;
        den_o       = DenW'(dl_w);
        num_o       = {zmag_w[43:0], 20'b0} + 64'(dl_w[21:1]);
      end
      OpEdiv: begin
        div_start_o = 1'b1;
        den_o       = de_w;
        num_o       = smag_w[DivW-1:0] + 64'(de_w[DenW-1:1]);
      end
      default: begin
        div_start_o = 1'b0;
      end
    endcase
  end

  // Rounded quotient of the evaluation, saturated to 32 bits.
  cbs_res_t eout_w;
  always_comb begin
    eout_w.status      = StOk;
    eout_w.curve_value = '0;
    if (sum2_q == '0) begin
      eout_w.status = StNoSupport;
    end else if (!sum1_q[Sum1W-1]) begin
      eout_w.curve_value = (quot_i > 64'h7FFF_FFFF) ? 32'sh7FFF_FFFF : $signed(quot_i[31:0]);
    end else begin
      eout_w.curve_value = (quot_i > 64'h8000_0000) ? 32'sh8000_0000 : -$signed(quot_i[31:0]);
    end
  end

  logic ld_ok_w;
  assign ld_ok_w = (op_i == OpAccept) && !req_i.req_type && (pc_q < PCW'(MAX_POINTS));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q    <= '0;
      last_q  <= '0;
      ready_q <= 1'b0;
      i_q     <= '0;
      k_q     <= '0;
      valid_q <= 1'b0;
    end else begin
      valid_q <= (op_i == OpEout) || (op_i == OpEnr);
      if (ld_ok_w) pc_q <= pc_q + PCW'(1);
      unique case (op_i)
        OpSinit: i_q <= CW'(1);
        OpFz:    i_q <= i_q + CW'(1);
        OpLwr:   i_q <= i_q - CW'(1);
        OpBwr:   i_q <= i_q - CW'(1);
        OpSdone: begin
          last_q  <= CW'(pc_q) + CW'(1);
          ready_q <= 1'b1;
          pc_q    <= '0;
        end
        OpEw:    k_q <= '0;
        OpEacc:  k_q <= k_q + 2'd1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (op_i)
      OpAccept: req_q <= req_i;
      OpSinit: begin
        qprev_q <= -21'sd1048576;
        zprev_q <= '0;
      end
      OpFq: begin
        qcur_q <= $signed(quot_i[RatW-1:0]);
        prod_q <= prod_w;
      end
      OpFz: begin
        zprev_q <= z_fwd_w;
        qprev_q <= qcur_q;
      end
      OpLwr:  xnext_q <= x_last_w;
      OpBmul: prod_q <= prod_w;
      OpBwr:  xnext_q <= x_bk_w;
      OpEt2:  prod_q <= prod_w;
      OpEt3: begin
        t2_q   <= prod_hi_w;
        prod_q <= prod_w;
      end
      OpEs2: begin
        t3_q   <= prod_hi_w;
        prod_q <= prod_w;
      end
      OpEs3:  prod_q <= prod_w;
      OpEw: begin
        w_q[0] <= $signed(WgtW'(prod_hi_w));
        w_q[1] <= w1_w[WgtW-1:0];
        w_q[2] <= w2_w[WgtW-1:0];
        w_q[3] <= $signed(WgtW'(t3_q));
        sum1_q <= '0;
        sum2_q <= '0;
      end
      OpEmul: prod_q <= prod_w;
      OpEacc: begin
        if (incl_w) begin
          sum1_q <= sum1_q + Sum1W'(prod_q);
          sum2_q <= sum2_q + Sum2W'(w_q[k_q]);
        end
      end
      OpEout: res_q <= eout_w;
      OpEnr: begin
        res_q.curve_value <= '0;
        res_q.status      <= StNoCurve;
      end
      default: ;
    endcase
  end

  // Shape store: written on load beats, read during the forward pass.
  always_ff @(posedge clk_i) begin
    if (ld_ok_w) shape_mem[pc_q[SAW-1:0]] <= req_i.shape_value;
    if (op_i == OpFrd) shape_rd_q <= shape_mem[SAW'(i_q - CW'(1))];
  end

  // Control points hold z during the forward pass and x after the back pass.
  always_ff @(posedge clk_i) begin
    unique case (op_i)
      OpSinit: cp_mem[0]   <= '0;
      OpFz:    cp_mem[i_q] <= z_fwd_w;
      OpLwr:   cp_mem[i_q] <= x_last_w;
      OpBwr:   cp_mem[i_q] <= x_bk_w;
      default: ;
    endcase
    if (op_i == OpBrd) cp_rd_q <= cp_mem[i_q];
    else if (op_i == OpErd) cp_rd_q <= cp_mem[idx_w[CW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (op_i == OpSinit) piv_mem[0] <= -21'sd1048576;
    else if (op_i == OpFq) piv_mem[i_q] <= $signed(quot_i[RatW-1:0]);
    if (op_i == OpBrd) piv_rd_q <= piv_mem[i_q];
  end

  assign stat_o.is_eval    = req_q.req_type;
  assign stat_o.last_point = req_q.last_point;
  assign stat_o.ready      = ready_q;
  assign stat_o.div_done   = div_done_i;
  assign stat_o.fwd_end    = (i_q == CW'(pc_q));
  assign stat_o.bk_end     = (i_q == '0);
  assign stat_o.k_last     = (k_q == 2'd3);
  assign stat_o.sum_zero   = (sum2_q == '0);

  assign res_o   = res_q;
  assign valid_o = valid_q;

endmodule

// ===== design/cbs_ctrl.sv =====
// Controller state machine that sequences load, solve and evaluation.
module cbs_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  input  cbs_pkg::cbs_stat_t stat_i,
  output cbs_pkg::cbs_op_t   op_o,
  output logic               busy
);
  import cbs_pkg::*;

  localparam logic [4:0] SIdle   = 5'd0;
  localparam logic [4:0] SDec    = 5'd1;
  localparam logic [4:0] SSinit  = 5'd2;
  localparam logic [4:0] SFrd    = 5'd3;
  localparam logic [4:0] SFwait  = 5'd4;
  localparam logic [4:0] SFz     = 5'd5;
  localparam logic [4:0] SLstart = 5'd6;
  localparam logic [4:0] SLwait  = 5'd7;
  localparam logic [4:0] SBrd    = 5'd8;
  localparam logic [4:0] SBmul   = 5'd9;
  localparam logic [4:0] SBwr    = 5'd10;
  localparam logic [4:0] SSdone  = 5'd11;
  localparam logic [4:0] SEt2    = 5'd12;
  localparam logic [4:0] SEt3    = 5'd13;
  localparam logic [4:0] SEs2    = 5'd14;
  localparam logic [4:0] SEs3    = 5'd15;
  localparam logic [4:0] SEw     = 5'd16;
  localparam logic [4:0] SErd    = 5'd17;
  localparam logic [4:0] SEmul   = 5'd18;
  localparam logic [4:0] SEacc   = 5'd19;
  localparam logic [4:0] SEdiv   = 5'd20;
  localparam logic [4:0] SEwait  = 5'd21;
  localparam logic [4:0] SEnr    = 5'd22;

  logic [4:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    op_o    = OpNone;
    unique case (state_q)
      SIdle: begin
        if (start) begin
          op_o    = OpAccept;
          state_d = SDec;
        end
      end
      SDec: begin
        if (!stat_i.is_eval) state_d = stat_i.last_point ? SSinit : SIdle;
        else                 state_d = stat_i.ready ? SEt2 : SEnr;
      end
      SSinit: begin
        op_o    = OpSinit;
        state_d = SFrd;
      end
      SFrd: begin
        op_o    = OpFrd;
        state_d = SFwait;
      end
      SFwait: begin
        if (stat_i.div_done) begin
          op_o    = OpFq;
          state_d = SFz;
        end
      end
      SFz: begin
        op_o    = OpFz;
        state_d = stat_i.fwd_end ? SLstart : SFrd;
      end
      SLstart: begin
        op_o    = OpLstart;
        state_d = SLwait;
      end
      SLwait: begin
        if (stat_i.div_done) begin
          op_o    = OpLwr;
          state_d = SBrd;
        end
      end
      SBrd: begin
        op_o    = OpBrd;
        state_d = SBmul;
      end
      SBmul: begin
        op_o    = OpBmul;
        state_d = SBwr;
      end
      SBwr: begin
        op_o    = OpBwr;
        state_d = stat_i.bk_end ? SSdone : SBrd;
      end
      SSdone: begin
        op_o    = OpSdone;
        state_d = SIdle;
      end
      SEt2: begin
        op_o    = OpEt2;
        state_d = SEt3;
      end
      SEt3: begin
        op_o    = OpEt3;
        state_d = SEs2;
      end
      SEs2: begin
        op_o    = OpEs2;
        state_d = SEs3;
      end
      SEs3: begin
        op_o    = OpEs3;
        state_d = SEw;
      end
      SEw: begin
        op_o    = OpEw;
        state_d = SErd;
      end
      SErd: begin
        op_o    = OpErd;
        state_d = SEmul;
      end
      SEmul: begin
        op_o    = OpEmul;
        state_d = SEacc;
      end
      SEacc: begin
        op_o    = OpEacc;
        state_d = stat_i.k_last ? SEdiv : SErd;
      end
      SEdiv: begin
        // An empty weight sum is reported without a division.
        if (stat_i.sum_zero) begin
          op_o    = OpEout;
          state_d = SIdle;
        end else begin
          op_o    = OpEdiv;
          state_d = SEwait;
        end
      end
      SEwait: begin
        if (stat_i.div_done) begin
          op_o    = OpEout;
          state_d = SIdle;
        end
      end
      SEnr: begin
        op_o    = OpEnr;
        state_d = SIdle;
      end
      default: begin
        state_d = SIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= SIdle;
    else         state_q <= state_d;
  end

  assign busy = (state_q != SIdle);

endmodule

// ===== design/cubic_bspline_interpolator.sv =====
// Top level of the uniform cubic B-spline interpolator.
// A beat is taken when start is high and busy is low; busy stays high until the
// beat is finished, and an evaluate beat returns one result with valid_o high for
// exactly one cycle, which the receiver cannot hold off. A load marked last then
// runs the solve: a forward pass and a back pass over the loaded points, where
// every pivot ratio goes through the shared 64-step divider. An evaluate beat
// takes 4 basis products, 4 control point products and one 64-step division, and
// skips the division when the weight sum is zero; before any curve is solved it
// returns a no-curve status without evaluating.
module cubic_bspline_interpolator #(
  parameter int unsigned MAX_POINTS = cbs_pkg::MaxPointsDef,
  parameter int unsigned FRAC_BITS  = cbs_pkg::FracBitsDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  input  cbs_pkg::cbs_req_t req_i,
  output logic              busy,
  output cbs_pkg::cbs_res_t res_o,
  output logic              valid_o
);
  import cbs_pkg::*;

  cbs_op_t         op_w;
  cbs_stat_t       stat_w;
  logic            div_start_w, div_done_w;
  logic [DivW-1:0] num_w, quot_w;
  logic [DenW-1:0] den_w;

  cbs_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .stat_i (stat_w),
    .op_o   (op_w),
    .busy   (busy)
  );

  cbs_dp #(
    .MAX_POINTS (MAX_POINTS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .op_i        (op_w),
    .req_i       (req_i),
    .div_done_i  (div_done_w),
    .quot_i      (quot_w),
    .div_start_o (div_start_w),
    .num_o       (num_w),
    .den_o       (den_w),
    .stat_o      (stat_w),
    .res_o       (res_o),
    .valid_o     (valid_o)
  );

  cbs_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start_w),
    .num_i   (num_w),
    .den_i   (den_w),
    .done_o  (div_done_w),
    .quot_o  (quot_w)
  );

  a_result_from_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(busy))
    else $error("result strobe without a beat in progress");

  a_single_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |=> !valid_o)
    else $error("result strobe longer than one cycle");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("accepted beat did not raise busy");

endmodule
